>>> rtl/core/sjn_pkg.sv
// sjn_pkg: shared constants, codes and interface structs of the joint normalizer
// used by sjn_lane, sjn_merge and self_calibrating_joint_normalizer_core
// no dependencies
`default_nettype none

package sjn_pkg;

    // sizing
    localparam int NUM_GROUPS       = 6;
    localparam int JOINTS_PER_GROUP = 3;
    localparam int NUM_SAMPLES      = 3;
    localparam int NUM_LANES        = (JOINTS_PER_GROUP < NUM_SAMPLES) ?
                                      JOINTS_PER_GROUP : NUM_SAMPLES;
    localparam int LANE_DEPTH       = (NUM_GROUPS < 6) ? NUM_GROUPS : 6;
    localparam int LANE_IDX_W       = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;

    // fixed-point constants
    localparam logic [15:0] ONE_Q12  = 16'd4096;
    localparam logic [15:0] ONE_Q15  = 16'd32768;
    localparam logic [15:0] DIV3_MUL = 16'd43691;   // ceil(2^17 / 3)

    // group codes
    localparam logic [2:0] GRP_THUMB  = 3'd0;
    localparam logic [2:0] GRP_INDEX  = 3'd1;
    localparam logic [2:0] GRP_MIDDLE = 3'd2;
    localparam logic [2:0] GRP_RING   = 3'd3;
    localparam logic [2:0] GRP_PINKIE = 3'd4;
    localparam logic [2:0] GRP_WRIST  = 3'd5;

    // register indexes
    localparam logic [2:0] REG_THUMB_WA  = 3'd0;
    localparam logic [2:0] REG_THUMB_WB  = 3'd1;
    localparam logic [2:0] REG_THUMB_WC  = 3'd2;
    localparam logic [2:0] REG_PINKIE_WA = 3'd3;
    localparam logic [2:0] REG_PINKIE_WB = 3'd4;
    localparam logic [2:0] REG_PINKIE_WC = 3'd5;
    localparam logic [2:0] REG_MARGIN    = 3'd6;

    typedef struct packed {
        logic [15:0] thumb_a;
        logic [15:0] thumb_b;
        logic [15:0] thumb_c;
        logic [15:0] pinkie_a;
        logic [15:0] pinkie_b;
        logic [15:0] pinkie_c;
    } weights_t;

    typedef struct packed {
        logic               start;
        logic               active;
        logic [2:0]         group;
        logic signed [15:0] sample;
    } lane_req_t;

    typedef struct packed {
        logic        busy;
        logic [15:0] pos;
    } lane_rsp_t;

    typedef struct packed {
        logic       start;
        logic [2:0] group;
    } merge_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] drive;
    } merge_rsp_t;

    typedef logic [NUM_SAMPLES-1:0][15:0] pos_vec_t;

endpackage

`default_nettype wire

>>> rtl/core/self_calibrating_joint_normalizer_core.sv
// self_calibrating_joint_normalizer_core: top level, config registers, lanes, merge, output
// depends on sjn_pkg, sjn_lane, sjn_merge
//
// channel   signals                                          handshake
// config    cfg_wr_en, cfg_index, cfg_data                   write on cfg_wr_en
// request   group_index, sample_a, sample_b, sample_c        in_valid / in_stall
// result    group_echo, drive_position                       out_valid / out_stall
//
// one request at a time: from accept to a loaded result register it passes two multiplies,
// a check, the lane's 15-step serial divider (skipped when the check clamps), a merge
// accumulate over the three positions, a scale step and the ST_LANES/ST_MERGE/ST_OUT handoff;
// an unused group code goes from accept straight to ST_OUT with drive_position zero.
// reset restores the per-joint extremes (low 1.0, high 0) and the default registers.
// a stalled result holds in the output register while the next request is taken.
`default_nettype none

module self_calibrating_joint_normalizer_core import sjn_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  group_index,
    input  wire logic signed [15:0] sample_a,
    input  wire logic signed [15:0] sample_b,
    input  wire logic signed [15:0] sample_c,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       group_echo,
    output logic [15:0]      drive_position
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LANES = 2'd1;
    localparam logic [1:0] ST_MERGE = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]  state_reg, state_next;
    weights_t    weights_reg;
    logic [14:0] margin_reg;
    logic [2:0]  group_reg, group_next;
    logic [15:0] res_reg, res_next;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  echo_reg;
    logic [15:0] drive_reg;
    logic        load_out;

    logic        accept;
    logic        group_ok;
    logic        wrist;
    logic signed [15:0] samples [NUM_SAMPLES];
    lane_req_t   lane_req [NUM_SAMPLES];
    lane_rsp_t   lane_rsp [NUM_SAMPLES];
    pos_vec_t    pos;
    logic        lanes_busy;
    merge_req_t  merge_req;
    merge_rsp_t  merge_rsp;

    assign accept   = in_valid && !in_stall;
    assign group_ok = ({2'b00, group_index} < 5'(NUM_GROUPS)) && (group_index <= GRP_WRIST);
    assign wrist    = (group_index == GRP_WRIST);

    assign samples[0] = sample_a;
    assign samples[1] = sample_b;
    assign samples[2] = sample_c;

    genvar j;
    generate
        for (j = 0; j < NUM_SAMPLES; j++)
        begin : g_lane
            assign lane_req[j].start  = accept && group_ok;
            // wrist has two joints only
            assign lane_req[j].active = group_ok && !(wrist && (j == 2));
            assign lane_req[j].group  = group_index;
            assign lane_req[j].sample = samples[j];
            if (j < NUM_LANES)
            begin : g_on
                sjn_lane u_lane
                (
                    .clk    (clk),
                    .rst_n  (rst_n),
                    .req    (lane_req[j]),
                    .margin (margin_reg),
                    .rsp    (lane_rsp[j])
                );
            end
            else
            begin : g_off
                assign lane_rsp[j].busy = 1'b0;
                assign lane_rsp[j].pos  = 16'd0;
            end
            assign pos[j] = lane_rsp[j].pos;
        end
    endgenerate

    assign lanes_busy = lane_rsp[0].busy || lane_rsp[1].busy || lane_rsp[2].busy;

    assign merge_req.start = (state_reg == ST_LANES) && !lanes_busy;
    assign merge_req.group = group_reg;

    sjn_merge u_merge
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (merge_req),
        .pos     (pos),
        .weights (weights_reg),
        .rsp     (merge_rsp)
    );

    assign load_out = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        group_next     = group_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    group_next = group_index;
                    if (group_ok)
                    begin
                        state_next = ST_LANES;
                    end
                    else
                    begin
                        res_next   = 16'd0;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_LANES:
            begin
                if (!lanes_busy)
                    state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                if (merge_rsp.done)
                begin
                    res_next   = merge_rsp.drive;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        group_reg <= group_next;
        res_reg   <= res_next;
        if (load_out)
        begin
            echo_reg  <= group_reg;
            drive_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weights_reg.thumb_a  <= 16'd0;
            weights_reg.thumb_b  <= ONE_Q15;
            weights_reg.thumb_c  <= 16'd0;
            weights_reg.pinkie_a <= 16'd0;
            weights_reg.pinkie_b <= ONE_Q15;
            weights_reg.pinkie_c <= 16'd0;
            margin_reg           <= 15'd6554;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_THUMB_WA:  weights_reg.thumb_a  <= cfg_data;
                REG_THUMB_WB:  weights_reg.thumb_b  <= cfg_data;
                REG_THUMB_WC:  weights_reg.thumb_c  <= cfg_data;
                REG_PINKIE_WA: weights_reg.pinkie_a <= cfg_data;
                REG_PINKIE_WB: weights_reg.pinkie_b <= cfg_data;
                REG_PINKIE_WC: weights_reg.pinkie_c <= cfg_data;
                REG_MARGIN:    margin_reg           <= cfg_data[14:0];
                default:       ;
            endcase
        end
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign group_echo     = echo_reg;
    assign drive_position = drive_reg;

endmodule

`default_nettype wire

>>> rtl/core/sjn_lane.sv
// sjn_lane: one joint lane: running min/max per group, window scaling, serial divider
// depends on sjn_pkg
`default_nettype none

module sjn_lane import sjn_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire lane_req_t req,
    input  wire logic [14:0] margin,
    output lane_rsp_t      rsp
);

    localparam logic [2:0] L_IDLE    = 3'd0;
    localparam logic [2:0] L_MUL_ES  = 3'd1;
    localparam logic [2:0] L_MUL_DEN = 3'd2;
    localparam logic [2:0] L_CHECK   = 3'd3;
    localparam logic [2:0] L_DIV     = 3'd4;

    localparam logic [3:0] DIV_LAST = 4'd14;

    logic [2:0]         state_reg, state_next;
    logic signed [15:0] lo_reg [LANE_DEPTH];
    logic signed [15:0] hi_reg [LANE_DEPTH];
    logic [15:0]        d_reg, d_next;
    logic [15:0]        s_reg, s_next;
    logic [30:0]        es_reg, es_next;
    logic [32:0]        den_reg, den_next;
    logic [31:0]        rem_reg, rem_next;
    logic [14:0]        q_reg, q_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [15:0]        pos_reg, pos_next;

    logic [LANE_IDX_W-1:0] idx;
    logic                  in_range;
    logic                  load;
    logic signed [15:0]    lo_cur, hi_cur, lo_new, hi_new;
    logic signed [16:0]    span;
    logic signed [16:0]    delta;
    logic [16:0]           scale_fac;
    logic signed [33:0]    num;
    logic [32:0]           rem_sh;

    assign idx      = req.group[LANE_IDX_W-1:0];
    assign in_range = ({{(32-LANE_IDX_W){1'b0}}, idx} < 32'(LANE_DEPTH));
    assign load     = (state_reg == L_IDLE) && req.start && req.active && in_range;

    always_comb
    begin
        lo_cur    = in_range ? lo_reg[idx] : $signed(ONE_Q12);
        hi_cur    = in_range ? hi_reg[idx] : 16'sd0;
        lo_new    = (req.sample < lo_cur) ? req.sample : lo_cur;
        hi_new    = (req.sample > hi_cur) ? req.sample : hi_cur;
        span      = {hi_new[15], hi_new} - {lo_new[15], lo_new};
        delta     = {req.sample[15], req.sample} - {lo_new[15], lo_new};
        scale_fac = 17'h10000 - {1'b0, margin, 1'b0};
        num       = $signed({2'b00, d_reg, 16'h0000}) - $signed({3'b000, es_reg});
        rem_sh    = {rem_reg, 1'b0};

        state_next = state_reg;
        d_next     = d_reg;
        s_next     = s_reg;
        es_next    = es_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;

        case (state_reg)
            L_IDLE:
            begin
                if (req.start)
                begin
                    if (load)
                    begin
                        d_next     = delta[15:0];
                        s_next     = (span <= 17'sd0) ? ONE_Q12 : span[15:0];
                        state_next = L_MUL_ES;
                    end
                    else
                    begin
                        // joint not used by this group contributes zero
                        pos_next = 16'd0;
                    end
                end
            end
            L_MUL_ES:
            begin
                es_next    = 31'(margin) * 31'(s_reg);
                state_next = L_MUL_DEN;
            end
            L_MUL_DEN:
            begin
                den_next   = 33'(s_reg) * 33'(scale_fac);
                state_next = L_CHECK;
            end
            L_CHECK:
            begin
                if (num <= 34'sd0)
                begin
                    pos_next   = 16'd0;
                    state_next = L_IDLE;
                end
                else if ({1'b0, num[31:0]} >= den_reg)
                begin
                    pos_next   = ONE_Q15;
                    state_next = L_IDLE;
                end
                else
                begin
                    rem_next   = num[31:0];
                    q_next     = 15'd0;
                    cnt_next   = 4'd0;
                    state_next = L_DIV;
                end
            end
            L_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (rem_sh >= den_reg)
                begin
                    rem_next = 32'(rem_sh - den_reg);
                    q_next   = {q_reg[13:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[31:0];
                    q_next   = {q_reg[13:0], 1'b0};
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    pos_next   = {1'b0, q_next};
                    state_next = L_IDLE;
                end
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            pos_reg   <= 16'd0;
            for (int i = 0; i < LANE_DEPTH; i++)
            begin
                lo_reg[i] <= $signed(ONE_Q12);
                hi_reg[i] <= 16'sd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            if (load)
            begin
                lo_reg[idx] <= lo_new;
                hi_reg[idx] <= hi_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg   <= d_next;
        s_reg   <= s_next;
        es_reg  <= es_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.busy = (state_reg != L_IDLE);
    assign rsp.pos  = pos_reg;

endmodule

`default_nettype wire

>>> rtl/core/sjn_merge.sv
// sjn_merge: combines lane positions (weighted sum or mean) into the drive position
// depends on sjn_pkg
`default_nettype none

module sjn_merge import sjn_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire merge_req_t req,
    input  wire pos_vec_t   pos,
    input  wire weights_t   weights,
    output merge_rsp_t      rsp
);

    localparam logic [1:0] M_IDLE  = 2'd0;
    localparam logic [1:0] M_ACC   = 2'd1;
    localparam logic [1:0] M_SCALE = 2'd2;
    localparam logic [1:0] M_FIN   = 2'd3;

    localparam logic [1:0] K_LAST = 2'(NUM_SAMPLES - 1);

    logic [1:0]  state_reg, state_next;
    logic [1:0]  k_reg, k_next;
    logic [2:0]  group_reg, group_next;
    logic [33:0] acc_reg, acc_next;
    logic [18:0] raw_reg, raw_next;
    logic [16:0] div3_reg, div3_next;

    logic [15:0] w_sel;
    logic [31:0] prod;
    logic [33:0] div3_prod;
    logic [18:0] combined;
    logic        done;

    always_comb
    begin
        // mean groups use weight one so the >>15 leaves the plain sum
        w_sel = ONE_Q15;
        if (group_reg == GRP_THUMB)
        begin
            case (k_reg)
                2'd0:    w_sel = weights.thumb_a;
                2'd1:    w_sel = weights.thumb_b;
                default: w_sel = weights.thumb_c;
            endcase
        end
        else if (group_reg == GRP_PINKIE)
        begin
            case (k_reg)
                2'd0:    w_sel = weights.pinkie_a;
                2'd1:    w_sel = weights.pinkie_b;
                default: w_sel = weights.pinkie_c;
            endcase
        end

        prod      = pos[k_reg] * w_sel;
        // sum of three positions stays below 2^17, where the reciprocal is exact
        div3_prod = 34'(acc_reg[31:15]) * 34'(DIV3_MUL);

        if (group_reg == GRP_THUMB || group_reg == GRP_PINKIE)
            combined = raw_reg;
        else if (group_reg == GRP_WRIST)
            combined = {1'b0, raw_reg[18:1]};
        else
            combined = {2'b00, div3_reg};

        state_next = state_reg;
        k_next     = k_reg;
        group_next = group_reg;
        acc_next   = acc_reg;
        raw_next   = raw_reg;
        div3_next  = div3_reg;
        done       = 1'b0;

        case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    group_next = req.group;
                    k_next     = 2'd0;
                    acc_next   = 34'd0;
                    state_next = M_ACC;
                end
            end
            M_ACC:
            begin
                acc_next = acc_reg + 34'(prod);
                k_next   = k_reg + 2'd1;
                if (k_reg == K_LAST)
                    state_next = M_SCALE;
            end
            M_SCALE:
            begin
                raw_next   = acc_reg[33:15];
                div3_next  = div3_prod[33:17];
                state_next = M_FIN;
            end
            M_FIN:
            begin
                done       = 1'b1;
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        group_reg <= group_next;
        acc_reg   <= acc_next;
        raw_reg   <= raw_next;
        div3_reg  <= div3_next;
    end

    assign rsp.done  = done;
    assign rsp.drive = (combined >= 19'(ONE_Q15)) ? 16'd0 :
                       16'(19'(ONE_Q15) - combined);

endmodule

`default_nettype wire

>>> test/self_calibrating_joint_normalizer_core_test.sv
// self_calibrating_joint_normalizer_core_test: self-checking testbench for the joint normalizer core
// tracks per-joint extremes, margin window and group combining in its own predictor
// depends on sjn_pkg and self_calibrating_joint_normalizer_core
`timescale 1ns / 100ps

module self_calibrating_joint_normalizer_core_test;
    import sjn_pkg::*;

    localparam logic [2:0] REG_UNUSED     = 3'd7;
    localparam logic [2:0] GRP_UNUSED_LO  = 3'd6;
    localparam logic [2:0] GRP_UNUSED_HI  = 3'd7;
    localparam int         IDLE_LIMIT     = 1000;
    localparam int         SETTLE_CYCLES  = 30;
    localparam int         FULL_WINDOW    = 32768;

    typedef struct packed {
        logic [2:0]         grp;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
    } joint_request_t;

    typedef struct {
        logic [2:0]  grp;
        logic [15:0] drive;
    } joint_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [2:0] cfg_index = REG_THUMB_WA;
    logic [15:0] cfg_data = 16'd0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [2:0] group_index = GRP_THUMB;
    logic signed [15:0] sample_a = 16'sd0;
    logic signed [15:0] sample_b = 16'sd0;
    logic signed [15:0] sample_c = 16'sd0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [2:0] group_echo;
    logic [15:0] drive_position;

    // predictor copy of the registers and the per-joint extremes
    logic [15:0]        thumb_weight [3] = '{16'd0, 16'd32768, 16'd0};
    logic [15:0]        pinkie_weight [3] = '{16'd0, 16'd32768, 16'd0};
    logic [14:0]        trim_margin = 15'd6554;
    logic signed [15:0] joint_floor [NUM_GROUPS*JOINTS_PER_GROUP];
    logic signed [15:0] joint_ceiling [NUM_GROUPS*JOINTS_PER_GROUP];

    joint_result_t expected_drives[$];
    int            mismatch_count = 0;
    int            idle_cycles = 0;
    bit            traffic_gaps = 1'b1;
    bit            result_stalls = 1'b1;

    self_calibrating_joint_normalizer_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .group_index    (group_index),
        .sample_a       (sample_a),
        .sample_b       (sample_b),
        .sample_c       (sample_c),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .group_echo     (group_echo),
        .drive_position (drive_position)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // updates one joint's extremes and returns its window position in Q1.15
    function automatic logic [15:0] track_joint(int slot, logic signed [15:0] x);
        longint lo, hi, span, num, den, q, e;
        lo = joint_floor[slot];
        hi = joint_ceiling[slot];
        if (x < lo)
            lo = x;
        if (x > hi)
            hi = x;
        joint_floor[slot] = 16'(lo);
        joint_ceiling[slot] = 16'(hi);
        span = hi - lo;
        if (span <= 0)
            span = longint'(ONE_Q12);
        e = longint'(trim_margin);
        num = (longint'(x) - lo) * 65536 - e * span;
        if (num <= 0)
            return 16'd0;
        den = span * (65536 - 2 * e);
        q = (num * longint'(ONE_Q15)) / den;
        return (q > longint'(ONE_Q15)) ? ONE_Q15 : 16'(q);
    endfunction

    function automatic logic [15:0] predict_drive(joint_request_t req);
        logic [15:0]        pos [3];
        logic signed [15:0] samples [3];
        longint unsigned    combined;
        int                 joints;
        pos = '{16'd0, 16'd0, 16'd0};
        samples = '{req.a, req.b, req.c};
        if (req.grp >= NUM_GROUPS || req.grp > GRP_WRIST)
            return 16'd0;
        joints = (req.grp == GRP_WRIST) ? 2 : 3;
        for (int j = 0; j < joints; j++)
        begin
            if (j < JOINTS_PER_GROUP)
                pos[j] = track_joint(int'(req.grp) * JOINTS_PER_GROUP + j, samples[j]);
        end
        case (req.grp)
            GRP_THUMB:
                combined = (pos[0] * thumb_weight[0] + pos[1] * thumb_weight[1] +
                            pos[2] * thumb_weight[2]) >> 15;
            GRP_PINKIE:
                combined = (pos[0] * pinkie_weight[0] + pos[1] * pinkie_weight[1] +
                            pos[2] * pinkie_weight[2]) >> 15;
            GRP_WRIST:
                combined = (pos[0] + pos[1]) / 2;
            default:
                combined = (pos[0] + pos[1] + pos[2]) / 3;
        endcase
        return (combined >= ONE_Q15) ? 16'd0 : 16'(ONE_Q15 - combined);
    endfunction

    function automatic logic signed [15:0] random_sample(int window);
        int v;
        if (window >= FULL_WINDOW)
            return 16'($urandom);
        v = int'($urandom_range(0, 2 * window)) - window;
        return 16'(v);
    endfunction

    function automatic joint_request_t random_request(int window);
        joint_request_t req;
        if ($urandom_range(0, 15) == 0)
            req.grp = 3'($urandom_range(GRP_UNUSED_LO, GRP_UNUSED_HI));
        else
            req.grp = 3'($urandom_range(GRP_THUMB, GRP_WRIST));
        req.a = random_sample(window);
        req.b = random_sample(window);
        req.c = random_sample(window);
        return req;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        $display("ERROR at %0t: %s, expected %0d, got %0d", $time, what, want, got);
    endtask

    // drives one request and holds it until the core takes it
    task automatic send_request(input joint_request_t req);
        if (traffic_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        group_index <= req.grp;
        sample_a <= req.a;
        sample_b <= req.b;
        sample_c <= req.c;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        expected_drives.push_back('{req.grp, predict_drive(req)});
    endtask

    task automatic send_random(input int count, input int window);
        repeat (count) send_request(random_request(window));
    endtask

    // drains outstanding results so registers change only while the core is idle
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (expected_drives.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [15:0] ta, input logic [15:0] tb,
                                  input logic [15:0] tc, input logic [15:0] pa,
                                  input logic [15:0] pb, input logic [15:0] pc,
                                  input logic [15:0] margin_data);
        logic [15:0] regs [8];
        wait_for_idle();
        regs[REG_THUMB_WA]  = ta;
        regs[REG_THUMB_WB]  = tb;
        regs[REG_THUMB_WC]  = tc;
        regs[REG_PINKIE_WA] = pa;
        regs[REG_PINKIE_WB] = pb;
        regs[REG_PINKIE_WC] = pc;
        regs[REG_MARGIN]    = margin_data;
        regs[REG_UNUSED]    = 16'($urandom);
        for (int i = 0; i < 8; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= regs[i];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        thumb_weight = '{ta, tb, tc};
        pinkie_weight = '{pa, pb, pc};
        trim_margin = margin_data[14:0];
    endtask

    task automatic apply_random_settings();
        logic [15:0] w [6];
        for (int i = 0; i < 6; i++)
            w[i] = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
        apply_settings(w[0], w[1], w[2], w[3], w[4], w[5], 16'($urandom_range(0, 32767)));
    endtask

    // default registers; first requests see a zero span, then window edges
    task automatic test_reset_defaults();
        for (int g = GRP_THUMB; g <= GRP_UNUSED_HI; g++)
            send_request('{3'(g), 16'sd0, 16'sd0, 16'sd0});
        send_request('{GRP_THUMB, 16'sd4096, 16'sd4096, 16'sd4096});
        send_request('{GRP_THUMB, -16'sd4096, -16'sd4096, -16'sd4096});
        send_request('{GRP_THUMB, 16'sd0, 16'sd1000, -16'sd1000});
        send_request('{GRP_INDEX, 16'sd2048, -16'sd2048, 16'sd819});
        send_request('{GRP_MIDDLE, -16'sd3000, 16'sd3000, 16'sd1500});
        send_request('{GRP_RING, 16'sd500, 16'sd500, -16'sd500});
        send_request('{GRP_PINKIE, 16'sd1200, -16'sd1200, 16'sd4000});
        send_request('{GRP_PINKIE, 16'sd600, 16'sd0, 16'sd2000});
        send_request('{GRP_WRIST, 16'sd3000, -16'sd3000, -16'sd32768});
        send_request('{GRP_WRIST, 16'sd100, 16'sd200, 16'sd32767});
        // unused codes must leave the extremes alone even for full-scale samples
        send_request('{GRP_UNUSED_LO, 16'sd32767, -16'sd32768, 16'sd0});
        send_request('{GRP_UNUSED_HI, -16'sd32768, 16'sd32767, -16'sd1});
    endtask

    task automatic test_register_extremes();
        apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_random(80, 2000);
        apply_settings(16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd32768,
                       16'd32767);
        send_random(80, 3000);
        // heavy weights saturate the combined value; margin bit 15 is not stored
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_random(80, 4000);
    endtask

    task automatic test_random_settings();
        int windows [4] = '{6000, 10000, 16000, 24000};
        foreach (windows[k])
        begin
            apply_random_settings();
            send_random(200, windows[k]);
        end
    endtask

    task automatic test_field_extremes();
        apply_random_settings();
        for (int g = GRP_THUMB; g <= GRP_UNUSED_HI; g++)
        begin
            send_request('{3'(g), -16'sd32768, 16'sd32767, -16'sd32768});
            send_request('{3'(g), 16'sd32767, -16'sd32768, 16'sd32767});
        end
        send_random(100, FULL_WINDOW);
    endtask

    task automatic test_steady_flow();
        apply_settings(16'd10923, 16'd10923, 16'd10922, 16'd16384, 16'd8192, 16'd8192,
                       16'd6554);
        traffic_gaps = 1'b0;
        result_stalls = 1'b0;
        send_random(300, FULL_WINDOW);
    endtask

    always @(posedge clk)
    begin
        if (result_stalls && $urandom_range(0, 3) == 0)
        begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        joint_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_drives.size() == 0)
                report_mismatch("result with no request pending", -1, int'(group_echo));
            else
            begin
                want = expected_drives.pop_front();
                if (group_echo !== want.grp)
                    report_mismatch("group_echo", int'(want.grp), int'(group_echo));
                if (drive_position !== want.drive)
                    report_mismatch("drive_position", int'(want.drive), int'(drive_position));
            end
        end
    end

    // ends the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("watchdog expired at %0t", $time);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        for (int i = 0; i < NUM_GROUPS * JOINTS_PER_GROUP; i++)
        begin
            joint_floor[i] = ONE_Q12;
            joint_ceiling[i] = 16'sd0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_register_extremes();
        test_random_settings();
        test_field_extremes();
        test_steady_flow();
        wait_for_idle();
        if (expected_drives.size() != 0)
            report_mismatch("requests left without result", 0, expected_drives.size());
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> self_calibrating_joint_normalizer_core.f
rtl/core/sjn_pkg.sv
rtl/core/sjn_lane.sv
rtl/core/sjn_merge.sv
rtl/core/self_calibrating_joint_normalizer_core.sv
test/self_calibrating_joint_normalizer_core_test.sv
